[rtl/rwsp_pkg.sv]
// ----------------------------------------------------------------------------
// rwsp_pkg: shared types and constants for the wall slice projection
// Field widths, colors, configuration register codes, the side-band word that
// rides along the divider stages, and the quarter-wave cosine entry function.
// ----------------------------------------------------------------------------
package rwsp_pkg;

  // Field widths of the ray and span words.
  localparam int COLUMN_W = 11;
  localparam int DIST_W   = 24;
  localparam int ANGLE_W  = 12;
  localparam int SCREEN_W = 12;
  localparam int PPD_W    = 24;
  localparam int COLOR_W  = 24;

  // Cosine magnitude is Q1.14, so it takes 15 bits.
  localparam int COS_W    = 15;
  localparam int COS_FRAC = 14;

  // Wall height is a 16-bit integer that saturates at its maximum.
  localparam int QUO_W = 16;
  localparam logic [QUO_W-1:0] HEIGHT_MAX = 16'hffff;

  localparam logic [COLOR_W-1:0] COLOR_VERT = 24'hffffff;
  localparam logic [COLOR_W-1:0] COLOR_HORZ = 24'hcccccc;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_HEIGHT = 1'b0,
    REG_PROJ_DIST     = 1'b1
  } cfg_reg_t;

  // Per-ray flags carried through the divider.
  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic                hit_vertical;
    logic                neg;
    logic                sat;
  } side_t;

  // Fixed-point constants of the cosine series.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  // Quarter-wave cosine entry k, Q1.14, from an eight-term Taylor series in
  // Q30. Used only at elaboration to fill the cosine table.
  function automatic logic [COS_W-1:0] quarter_cos(input logic [63:0] k,
                                                   input int angle_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x   = (k * HALF_PI_Q30) >> (angle_bits - 2);
    x2  = (x * x) >> 30;
    t   = ONE_Q30;
    sum = $signed(ONE_Q30);
    t   = ((t * x2) >> 30) / 64'd2;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd12;
    sum = sum + $signed(t);
    t   = ((t * x2) >> 30) / 64'd30;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd56;
    sum = sum + $signed(t);
    t   = ((t * x2) >> 30) / 64'd90;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd132;
    sum = sum + $signed(t);
    t   = ((t * x2) >> 30) / 64'd182;
    sum = sum - $signed(t);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = ($unsigned(sum) + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return r[COS_W-1:0];
  endfunction

endpackage

[rtl/rwsp_if.sv]
// ----------------------------------------------------------------------------
// rwsp_if: ray and span channels
// Valid/ready channels for the cast ray words coming in and the wall span
// words going out. A word moves at a rising edge with valid and ready high.
// ----------------------------------------------------------------------------

// Cast ray channel.
interface rwsp_ray_if;
  logic                              valid;
  logic                              ready;
  logic [rwsp_pkg::COLUMN_W-1:0]     column;
  logic [rwsp_pkg::DIST_W-1:0]       ray_distance;
  logic [rwsp_pkg::ANGLE_W-1:0]      cast_angle;
  logic [rwsp_pkg::ANGLE_W-1:0]      player_angle;
  logic                              hit_vertical;

  modport source (
    output valid, column, ray_distance, cast_angle, player_angle, hit_vertical,
    input  ready
  );
  modport sink (
    input  valid, column, ray_distance, cast_angle, player_angle, hit_vertical,
    output ready
  );
endinterface

// Wall span channel.
interface rwsp_span_if;
  logic                              valid;
  logic                              ready;
  logic [rwsp_pkg::COLUMN_W-1:0]     column_out;
  logic [rwsp_pkg::SCREEN_W-1:0]     span_top;
  logic [rwsp_pkg::SCREEN_W-1:0]     span_bottom;
  logic [rwsp_pkg::COLOR_W-1:0]      wall_color;
  logic                              span_empty;

  modport source (
    output valid, column_out, span_top, span_bottom, wall_color, span_empty,
    input  ready
  );
  modport sink (
    input  valid, column_out, span_top, span_bottom, wall_color, span_empty,
    output ready
  );
endinterface

[rtl/rwsp_cos_rom.sv]
// ----------------------------------------------------------------------------
// rwsp_cos_rom: quarter-wave cosine table
// Holds cos(k*pi/(2Q)) in Q1.14 for k = 0..Q, Q = 2^(ANGLE_BITS-2). The table
// is fixed at elaboration; the read data is registered.
// ----------------------------------------------------------------------------
module rwsp_cos_rom #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [ANGLE_BITS-2:0]          addr,
  output logic [rwsp_pkg::COS_W-1:0]     data
);

  localparam int QUARTER = 1 << (ANGLE_BITS - 2);

  logic [rwsp_pkg::COS_W-1:0] rom [QUARTER+1];

  // Each entry is a constant worked out during elaboration.
  for (genvar k = 0; k <= QUARTER; k++) begin : g_entry
    localparam logic [rwsp_pkg::COS_W-1:0] Entry =
      rwsp_pkg::quarter_cos(64'(k), ANGLE_BITS);
    assign rom[k] = Entry;
  end

  // Registered read; the word holds while the stage is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

[rtl/rwsp_div_step.sv]
// ----------------------------------------------------------------------------
// rwsp_div_step: one restoring division stage
// Decides quotient bit BIT of numerator / perp by a single compare and
// subtract, and registers the partial remainder with its valid bit.
// ----------------------------------------------------------------------------
module rwsp_div_step #(
  parameter int NUM_W  = 31,
  parameter int PERP_W = 25,
  parameter int BIT    = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [NUM_W-1:0]              up_rem,
  input  logic [rwsp_pkg::QUO_W-1:0]    up_quo,
  input  logic [PERP_W-1:0]             up_perp,
  input  rwsp_pkg::side_t               up_side,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [NUM_W-1:0]              dn_rem,
  output logic [rwsp_pkg::QUO_W-1:0]    dn_quo,
  output logic [PERP_W-1:0]             dn_perp,
  output rwsp_pkg::side_t               dn_side
);

  localparam int CW = (NUM_W > PERP_W + BIT) ? NUM_W : PERP_W + BIT;

  logic [CW-1:0]                 rem_ext;
  logic [CW-1:0]                 div_ext;
  logic                          take;
  logic [NUM_W-1:0]              rem_next;
  logic [rwsp_pkg::QUO_W-1:0]    quo_next;

  // Compare the remainder against the shifted divisor and subtract on a fit.
  always_comb begin
    rem_ext  = CW'(up_rem);
    div_ext  = CW'(up_perp) << BIT;
    take     = rem_ext >= div_ext;
    rem_next = take ? NUM_W'(rem_ext - div_ext) : up_rem;
    quo_next = take ? (up_quo | (rwsp_pkg::QUO_W'(1) << BIT)) : up_quo;
  end

  assign up_ready = !dn_valid || dn_ready;

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_rem  <= rem_next;
      dn_quo  <= quo_next;
      dn_perp <= up_perp;
      dn_side <= up_side;
    end
  end

endmodule

[rtl/raycast_wall_slice_projection.sv]
// ----------------------------------------------------------------------------
// raycast_wall_slice_projection: wall span of one screen column
// Turns a cast ray into the vertical wall span and color for its column,
// with fisheye correction and a pipelined divider for the wall height.
// ----------------------------------------------------------------------------
// Usage:
//   ray   Cast ray words in (column, hit distance Q16.8, ray and player
//         binary angles, vertical-hit flag).
//   span  Wall span words out (column, top, bottom, color, empty flag).
//   cfg   Plain write port: cfg_write, cfg_index, cfg_data. Index 0 sets the
//         screen height, index 1 the projection-plane distance (Q16.8).
//         Write only while no word is in flight.
// Throughput is one word per clock while span is not stalled. A word accepted
// on ray passes through one input stage, the registered cosine table read,
// the distance multiply, the overflow check, sixteen divider stages of one
// quotient bit each, and the output register before it is presented on span.
// Every stage has its own valid bit and advances when the stage after it is
// empty or moving, so while span is stalled, ray keeps taking words until
// the pipeline is full; nothing is dropped or repeated.
// Reset empties the pipeline and loads the screen height with 480 and the
// projection-plane distance with 141900.
// ----------------------------------------------------------------------------
module raycast_wall_slice_projection #(
  parameter int TILE_UNITS = 64,
  parameter int ANGLE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [rwsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rwsp_pkg::CFG_DATA_W-1:0]      cfg_data,
  rwsp_ray_if.sink                             ray,
  rwsp_span_if.source                          span
);

  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int ADDR_W  = ANGLE_BITS - 1;
  localparam int DIFF_W  = (ANGLE_BITS > rwsp_pkg::ANGLE_W) ? ANGLE_BITS : rwsp_pkg::ANGLE_W;
  localparam int NUM_W   = rwsp_pkg::PPD_W + $clog2(TILE_UNITS + 1);
  localparam int PROD_W  = rwsp_pkg::DIST_W + rwsp_pkg::COS_W;
  localparam int PERP_W  = PROD_W - rwsp_pkg::COS_FRAC;
  localparam int CHK_W   = (NUM_W > PERP_W + rwsp_pkg::QUO_W) ? NUM_W
                                                               : PERP_W + rwsp_pkg::QUO_W;
  localparam int STEPS   = rwsp_pkg::QUO_W;

  // Configuration registers.
  logic [rwsp_pkg::SCREEN_W-1:0] screen_height;
  logic [rwsp_pkg::PPD_W-1:0]    proj_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= 12'd480;
      proj_dist     <= 24'd141900;
    end else if (cfg_write) begin
      case (rwsp_pkg::cfg_reg_t'(cfg_index))
        rwsp_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[rwsp_pkg::SCREEN_W-1:0];
        rwsp_pkg::REG_PROJ_DIST:     proj_dist     <= cfg_data[rwsp_pkg::PPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and ready chain.
  logic s1_valid, s2_valid, s3_valid, s4_valid, out_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

  logic             d_valid [STEPS+1];
  logic             d_ready [STEPS+1];
  logic [NUM_W-1:0] d_rem   [STEPS+1];
  logic [rwsp_pkg::QUO_W-1:0] d_quo [STEPS+1];
  logic [PERP_W-1:0]          d_perp [STEPS+1];
  rwsp_pkg::side_t            d_side [STEPS+1];

  assign out_ready = !out_valid || span.ready;
  assign s4_ready  = !s4_valid || d_ready[0];
  assign s3_ready  = !s3_valid || s4_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign ray.ready = s1_ready;
  assign d_ready[STEPS] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= ray.valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (s4_ready) begin
        s4_valid <= s3_valid;
      end
      if (out_ready) begin
        out_valid <= d_valid[STEPS];
      end
    end
  end

  // Stage 1: register the ray and the angle difference.
  logic [rwsp_pkg::COLUMN_W-1:0] s1_column;
  logic [rwsp_pkg::DIST_W-1:0]   s1_dist;
  logic                          s1_vert;
  logic [ANGLE_BITS-1:0]         s1_diff;
  logic [DIFF_W-1:0]             diff_full;

  assign diff_full = DIFF_W'(ray.cast_angle) - DIFF_W'(ray.player_angle);

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_column <= ray.column;
      s1_dist   <= ray.ray_distance;
      s1_vert   <= ray.hit_vertical;
      s1_diff   <= diff_full[ANGLE_BITS-1:0];
    end
  end

  // Stage 2: fold the angle into the first quadrant and read the table.
  logic [1:0]                  quad;
  logic [ANGLE_BITS-3:0]       quad_k;
  logic [ADDR_W-1:0]           rom_addr;
  logic [rwsp_pkg::COS_W-1:0]  s2_cos;
  logic [rwsp_pkg::COLUMN_W-1:0] s2_column;
  logic [rwsp_pkg::DIST_W-1:0]   s2_dist;
  logic                          s2_vert;
  logic                          s2_neg_quad;

  assign quad     = s1_diff[ANGLE_BITS-1:ANGLE_BITS-2];
  assign quad_k   = s1_diff[ANGLE_BITS-3:0];
  assign rom_addr = quad[0] ? (ADDR_W'(QUARTER) - ADDR_W'(quad_k)) : ADDR_W'(quad_k);

  rwsp_cos_rom #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cos_rom (
    .clk  (clk),
    .en   (s2_ready),
    .addr (rom_addr),
    .data (s2_cos)
  );

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_column   <= s1_column;
      s2_dist     <= s1_dist;
      s2_vert     <= s1_vert;
      s2_neg_quad <= (quad == 2'd1) || (quad == 2'd2);
    end
  end

  // Stage 3: perpendicular distance and the height numerator.
  logic [PROD_W-1:0]             prod;
  logic [PERP_W-1:0]             s3_perp;
  logic [NUM_W-1:0]              s3_num;
  logic [rwsp_pkg::COLUMN_W-1:0] s3_column;
  logic                          s3_vert;
  logic                          s3_neg;

  assign prod = PROD_W'(s2_dist) * PROD_W'(s2_cos);

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_perp   <= prod[PROD_W-1:rwsp_pkg::COS_FRAC];
      s3_num    <= NUM_W'(proj_dist) * NUM_W'(TILE_UNITS);
      s3_column <= s2_column;
      s3_vert   <= s2_vert;
      // A negative zero is not a negative cosine.
      s3_neg    <= s2_neg_quad && (s2_cos != '0);
    end
  end

  // Stage 4: saturation check, height would reach 65536 or perp is zero.
  logic [CHK_W-1:0] num_ext;
  logic [CHK_W-1:0] lim_ext;
  logic             sat;
  logic [NUM_W-1:0]           s4_num;
  logic [PERP_W-1:0]          s4_perp;
  rwsp_pkg::side_t            s4_side;

  assign num_ext = CHK_W'(s3_num);
  assign lim_ext = CHK_W'(s3_perp) << rwsp_pkg::QUO_W;
  assign sat     = (s3_perp == '0) || (num_ext >= lim_ext);

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_num               <= s3_num;
      s4_perp              <= s3_perp;
      s4_side.column       <= s3_column;
      s4_side.hit_vertical <= s3_vert;
      s4_side.neg          <= s3_neg;
      s4_side.sat          <= sat;
    end
  end

  assign d_valid[0] = s4_valid;
  assign d_rem[0]   = s4_num;
  assign d_quo[0]   = '0;
  assign d_perp[0]  = s4_perp;
  assign d_side[0]  = s4_side;

  // Divider: one quotient bit per stage, most significant first.
  for (genvar j = 0; j < STEPS; j++) begin : g_div
    rwsp_div_step #(
      .NUM_W  (NUM_W),
      .PERP_W (PERP_W),
      .BIT    (STEPS - 1 - j)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .up_valid (d_valid[j]),
      .up_ready (d_ready[j]),
      .up_rem   (d_rem[j]),
      .up_quo   (d_quo[j]),
      .up_perp  (d_perp[j]),
      .up_side  (d_side[j]),
      .dn_valid (d_valid[j+1]),
      .dn_ready (d_ready[j+1]),
      .dn_rem   (d_rem[j+1]),
      .dn_quo   (d_quo[j+1]),
      .dn_perp  (d_perp[j+1]),
      .dn_side  (d_side[j+1])
    );
  end

  // Output stage: span around mid-screen, clamped to the screen.
  rwsp_pkg::side_t               f_side;
  logic [rwsp_pkg::QUO_W-1:0]    height;
  logic [rwsp_pkg::QUO_W-2:0]    half;
  logic [rwsp_pkg::SCREEN_W-2:0] mid;
  logic [rwsp_pkg::QUO_W-1:0]    bot_sum;
  logic [rwsp_pkg::SCREEN_W-1:0] top_next;
  logic [rwsp_pkg::SCREEN_W-1:0] bottom_next;

  always_comb begin
    f_side  = d_side[STEPS];
    height  = f_side.sat ? rwsp_pkg::HEIGHT_MAX : d_quo[STEPS];
    half    = height[rwsp_pkg::QUO_W-1:1];
    mid     = screen_height[rwsp_pkg::SCREEN_W-1:1];
    bot_sum = rwsp_pkg::QUO_W'(mid) + rwsp_pkg::QUO_W'(half);
    if (f_side.neg) begin
      top_next    = rwsp_pkg::SCREEN_W'(mid);
      bottom_next = rwsp_pkg::SCREEN_W'(mid);
    end else begin
      if (rwsp_pkg::QUO_W'(half) > rwsp_pkg::QUO_W'(mid)) begin
        top_next = '0;
      end else begin
        top_next = rwsp_pkg::SCREEN_W'(mid - half[rwsp_pkg::SCREEN_W-2:0]);
      end
      if (bot_sum > rwsp_pkg::QUO_W'(screen_height)) begin
        bottom_next = screen_height;
      end else begin
        bottom_next = bot_sum[rwsp_pkg::SCREEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      span.column_out  <= f_side.column;
      span.span_top    <= top_next;
      span.span_bottom <= bottom_next;
      span.span_empty  <= top_next >= bottom_next;
      span.wall_color  <= f_side.hit_vertical ? rwsp_pkg::COLOR_VERT
                                              : rwsp_pkg::COLOR_HORZ;
    end
  end

  assign span.valid = out_valid;

endmodule

[rtl/rwsp_checker.sv]
// ----------------------------------------------------------------------------
// rwsp_checker: port-level checks for the wall slice projection
// Watches the ray and span channels of the top level and flags reset,
// backpressure and span consistency errors.
// ----------------------------------------------------------------------------
module rwsp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              ray_valid,
  input logic                              ray_ready,
  input logic                              span_valid,
  input logic                              span_ready,
  input logic [rwsp_pkg::COLUMN_W-1:0]     column_out,
  input logic [rwsp_pkg::SCREEN_W-1:0]     span_top,
  input logic [rwsp_pkg::SCREEN_W-1:0]     span_bottom,
  input logic [rwsp_pkg::COLOR_W-1:0]      wall_color,
  input logic                              span_empty
);

  // Reset leaves no word on the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !span_valid)
    else $error("span word valid right after reset");

  // A stalled span word stays and holds its value.
  a_span_hold: assert property (@(posedge clk) disable iff (rst)
    span_valid && !span_ready |=> span_valid &&
      $stable({column_out, span_top, span_bottom, wall_color, span_empty}))
    else $error("stalled span word changed or vanished");

  // The ray side only stalls when the pipeline is full behind a stalled output.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    ray_valid && !ray_ready |-> span_valid && !span_ready)
    else $error("ray stalled while the pipeline had room");

  // An empty span always collapses to one row, the top never passes the bottom.
  a_empty_point: assert property (@(posedge clk) disable iff (rst)
    span_valid && span_empty |-> span_top == span_bottom)
    else $error("empty span with top and bottom apart");

  // Only the two wall colors appear.
  a_color: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> wall_color == rwsp_pkg::COLOR_VERT ||
      wall_color == rwsp_pkg::COLOR_HORZ)
    else $error("unexpected wall color");

endmodule

bind raycast_wall_slice_projection rwsp_checker u_rwsp_checker (
  .clk         (clk),
  .rst         (rst),
  .ray_valid   (ray.valid),
  .ray_ready   (ray.ready),
  .span_valid  (span.valid),
  .span_ready  (span.ready),
  .column_out  (span.column_out),
  .span_top    (span.span_top),
  .span_bottom (span.span_bottom),
  .wall_color  (span.wall_color),
  .span_empty  (span.span_empty)
);

[sim/wall_span_checker.sv]
// ----------------------------------------------------------------------------
// wall_span_checker: span predictor and scoreboard for the projection block
// Watches the ray and span channels and the register write port. It computes
// the expected wall span of every accepted ray word and compares each
// accepted span word, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module wall_span_checker
  import rwsp_pkg::*;
#(
  parameter int TILE_UNITS = 64,
  parameter int ANGLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rwsp_ray_if                    ray,
  rwsp_span_if                   span,
  output int                     errors,
  output int                     pending,
  output int                     spans_checked,
  output int                     spans_empty
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int MAX_REPORTS = 10;
  localparam logic [SCREEN_W-1:0] RESET_SCREEN_HEIGHT = 12'd480;
  localparam logic [PPD_W-1:0] RESET_PROJ_DIST = 24'd141900;

  typedef struct packed {
    logic [COLUMN_W-1:0] column_out;
    logic [SCREEN_W-1:0] span_top;
    logic [SCREEN_W-1:0] span_bottom;
    logic [COLOR_W-1:0]  wall_color;
    logic                span_empty;
  } span_word_t;

  // Shadow copies of the two registers.
  logic [SCREEN_W-1:0] screen_height;
  logic [PPD_W-1:0]    proj_dist;

  // Quarter-wave cosine magnitudes in Q1.14, entries 0 through QUARTER.
  int unsigned cos_quarter [0:QUARTER];

  span_word_t expected_spans [$];

  // One quarter-wave entry: an eight-term Taylor series of cos(k*pi/(2Q))
  // summed in Q30, then rounded to nearest in Q1.14.
  function automatic int unsigned taylor_cos_q14(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    int              n;
    x    = (64'(k) * 64'd1686629713) / 64'(QUARTER);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (unsigned'(sum) + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return 32'(r);
  endfunction

  // Signed cosine of a binary angle, folded from the quarter wave.
  function automatic longint signed_cos(input logic [ANGLE_BITS-1:0] a);
    int quad;
    int k;
    quad = int'(a >> (ANGLE_BITS - 2));
    k    = int'(a) % QUARTER;
    case (quad)
      0:       return longint'(cos_quarter[k]);
      1:       return -longint'(cos_quarter[QUARTER - k]);
      2:       return -longint'(cos_quarter[k]);
      default: return longint'(cos_quarter[QUARTER - k]);
    endcase
  endfunction

  // Expected span of one ray under the current register values.
  function automatic span_word_t project_span(
    input logic [COLUMN_W-1:0] column,
    input logic [DIST_W-1:0]   hit_dist,
    input logic [ANGLE_W-1:0]  cast_angle,
    input logic [ANGLE_W-1:0]  player_angle,
    input logic                hit_vertical
  );
    logic [ANGLE_BITS-1:0] diff;
    longint                c;
    longint unsigned       h;
    longint unsigned       mid;
    longint unsigned       perp;
    longint unsigned       height;
    longint unsigned       half;
    longint unsigned       top;
    longint unsigned       bottom;
    span_word_t            w;
    diff = ANGLE_BITS'(cast_angle) - ANGLE_BITS'(player_angle);
    c    = signed_cos(diff);
    h    = 64'(screen_height);
    mid  = h / 2;
    if (c < 0) begin
      // Facing away from the wall: nothing to draw, centered.
      top    = mid;
      bottom = mid;
    end else begin
      perp = (64'(hit_dist) * unsigned'(c)) >> COS_FRAC;
      if (perp == 0) begin
        height = 64'(HEIGHT_MAX);
      end else begin
        height = (64'(TILE_UNITS) * 64'(proj_dist)) / perp;
        if (height > 64'(HEIGHT_MAX)) begin
          height = 64'(HEIGHT_MAX);
        end
      end
      half   = height / 2;
      top    = (half > mid) ? 64'd0 : mid - half;
      bottom = mid + half;
      if (bottom > h) begin
        bottom = h;
      end
    end
    w.column_out  = column;
    w.span_top    = top[SCREEN_W-1:0];
    w.span_bottom = bottom[SCREEN_W-1:0];
    w.wall_color  = hit_vertical ? COLOR_VERT : COLOR_HORZ;
    w.span_empty  = (top >= bottom);
    return w;
  endfunction

  initial begin
    for (int k = 0; k <= QUARTER; k++) begin
      cos_quarter[k] = taylor_cos_q14(k);
    end
  end

  // Track register writes, check span words and queue predictions.
  always @(posedge clk) begin : monitor
    span_word_t want;
    span_word_t got;
    if (rst) begin
      screen_height = RESET_SCREEN_HEIGHT;
      proj_dist     = RESET_PROJ_DIST;
      expected_spans.delete();
      errors        = 0;
      spans_checked = 0;
      spans_empty   = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SCREEN_HEIGHT: screen_height = cfg_data[SCREEN_W-1:0];
          REG_PROJ_DIST:     proj_dist     = cfg_data[PPD_W-1:0];
          default: ;
        endcase
      end

      // Compare a span word against the oldest prediction.
      if (span.valid && span.ready) begin
        got.column_out  = span.column_out;
        got.span_top    = span.span_top;
        got.span_bottom = span.span_bottom;
        got.wall_color  = span.wall_color;
        got.span_empty  = span.span_empty;
        if (expected_spans.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("unexpected span word: column %0d top %0d bottom %0d",
                     got.column_out, got.span_top, got.span_bottom);
          end
        end else begin
          want = expected_spans.pop_front();
          spans_checked++;
          if (want.span_empty) begin
            spans_empty++;
          end
          if (got.column_out !== want.column_out || got.span_top !== want.span_top ||
              got.span_bottom !== want.span_bottom ||
              got.wall_color !== want.wall_color ||
              got.span_empty !== want.span_empty) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("span mismatch: expected col %0d top %0d bot %0d color %06h empty %0b",
                       want.column_out, want.span_top, want.span_bottom,
                       want.wall_color, want.span_empty);
              $display("                    got col %0d top %0d bot %0d color %06h empty %0b",
                       got.column_out, got.span_top, got.span_bottom,
                       got.wall_color, got.span_empty);
            end
          end
        end
      end

      // Predict the span of a newly accepted ray word.
      if (ray.valid && ray.ready) begin
        expected_spans.push_back(project_span(ray.column, ray.ray_distance,
                                              ray.cast_angle, ray.player_angle,
                                              ray.hit_vertical));
      end
    end
    pending = expected_spans.size();
  end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: top level for the wall slice projection
// Drives directed and random ray words through the block under several
// register settings, with random idle gaps on both channels, and reports
// the verdict from the span checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rwsp_pkg::*;

  localparam int TILE_UNITS      = 64;
  localparam int ANGLE_BITS      = 12;
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 138;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 400000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int errors;
  int pending;
  int spans_checked;
  int spans_empty;
  int words_sent;
  int directed_words;
  int settings_used;
  int cycles;
  int stall_left;
  int phase;
  bit no_idle;

  rwsp_ray_if  ray_ch ();
  rwsp_span_if span_ch ();

  raycast_wall_slice_projection #(
    .TILE_UNITS (TILE_UNITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ray       (ray_ch),
    .span      (span_ch)
  );

  wall_span_checker #(
    .TILE_UNITS (TILE_UNITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .ray           (ray_ch),
    .span          (span_ch),
    .errors        (errors),
    .pending       (pending),
    .spans_checked (spans_checked),
    .spans_empty   (spans_empty)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d spans outstanding", cycles, pending);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 60) begin
      return 0;
    end else if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Span side: ready drops for random stretches.
  initial begin
    span_ch.ready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        span_ch.ready = 1'b0;
        stall_left--;
      end else begin
        span_ch.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = idle_cycles();
        end
      end
    end
  end

  // Present one ray word after an optional gap and hold it until taken.
  task automatic send_ray(input logic [COLUMN_W-1:0] col, input logic [DIST_W-1:0] hit_dist,
                          input logic [ANGLE_W-1:0] ra, input logic [ANGLE_W-1:0] pa,
                          input logic hv);
    int gap;
    gap = idle_cycles();
    @(negedge clk);
    if (gap > 0) begin
      ray_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    ray_ch.valid        = 1'b1;
    ray_ch.column       = col;
    ray_ch.ray_distance = hit_dist;
    ray_ch.cast_angle   = ra;
    ray_ch.player_angle = pa;
    ray_ch.hit_vertical = hv;
    @(posedge clk);
    while (!ray_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Random ray: angle offsets cluster around the view direction and the
  // quadrant boundaries, distances span near, typical, far and extreme.
  task automatic send_random_ray();
    logic [ANGLE_W-1:0] pa;
    logic [ANGLE_W-1:0] offset;
    logic [DIST_W-1:0]  hit_dist;
    int                 pick;
    pa   = ANGLE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      offset = ANGLE_W'(int'($urandom_range(0, 600)) - 300);
    end else if (pick < 65) begin
      offset = ANGLE_W'(1024 * $urandom_range(0, 3));
    end else if (pick < 75) begin
      offset = ANGLE_W'(1024 * $urandom_range(1, 3) + $urandom_range(0, 6) - 3);
    end else begin
      offset = ANGLE_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      hit_dist = '0;
    end else if (pick < 20) begin
      hit_dist = DIST_W'($urandom_range(1, 255));
    end else if (pick < 55) begin
      hit_dist = DIST_W'($urandom_range(1000, 200000));
    end else if (pick < 85) begin
      hit_dist = DIST_W'($urandom);
    end else begin
      hit_dist = DIST_W'(24'hffffff - $urandom_range(0, 4095));
    end
    send_ray(COLUMN_W'($urandom), hit_dist, pa + offset, pa, 1'($urandom));
  endtask

  // Register write once every span in flight has come out.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    ray_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Reset, directed words, then random phases under changing settings.
  initial begin
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = REG_SCREEN_HEIGHT;
    cfg_data            = '0;
    ray_ch.valid        = 1'b0;
    ray_ch.column       = '0;
    ray_ch.ray_distance = '0;
    ray_ch.cast_angle   = '0;
    ray_ch.player_angle = '0;
    ray_ch.hit_vertical = 1'b0;
    no_idle             = 1'b0;
    words_sent          = 0;
    settings_used       = 1;
    cycles              = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Directed words under the reset settings.
    send_ray(0, 0, 0, 0, 0);                       // zero distance
    send_ray(2047, 24'hffffff, 4095, 4095, 1);     // farthest, zero height
    send_ray(1, 2560, 0, 0, 0);
    send_ray(2, 100000, 1024, 0, 1);               // cosine exactly zero
    send_ray(3, 100000, 2048, 0, 0);               // cosine -1
    send_ray(4, 100000, 3072, 0, 1);               // cosine zero, fourth quadrant
    send_ray(5, 100000, 1025, 0, 0);               // just past a quarter turn
    send_ray(6, 100000, 0, 1, 1);                  // wrap to 4095
    send_ray(7, 100000, 1023, 0, 0);
    send_ray(8, 100000, 3073, 0, 1);
    send_ray(9, 1, 0, 0, 0);                       // height saturates
    send_ray(10, 138, 0, 0, 1);
    send_ray(11, 140, 0, 0, 0);
    send_ray(12, 18920, 0, 0, 1);                  // span fills the screen
    send_ray(13, 18921, 0, 0, 0);
    send_ray(14, 4000000, 0, 0, 1);
    send_ray(15, 9081600, 0, 0, 0);                // height one, half zero
    send_ray(16, 9081601, 0, 0, 1);                // height zero
    send_ray(17, 24'h800000, 512, 3584, 0);        // angle difference wraps
    send_ray(18, 50000, 100, 3000, 1);
    send_ray(19, 24'h5a5a5a, 12'haaa, 12'h555, 0);
    send_ray(1024, 24'ha5a5a5, 12'h555, 12'haaa, 1);
    directed_words = words_sent;

    // Random phases; one of them runs with no idling at all.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_SCREEN_HEIGHT, 24'd2048);
          write_reg(REG_PROJ_DIST, 24'hffffff);
        end
        1: begin
          write_reg(REG_SCREEN_HEIGHT, 24'd1);
          write_reg(REG_PROJ_DIST, 24'd0);
        end
        2: begin
          write_reg(REG_SCREEN_HEIGHT, 24'd2047);
          write_reg(REG_PROJ_DIST, 24'd1);
        end
        3: begin
          // Bits above the register width are dropped.
          write_reg(REG_SCREEN_HEIGHT, 24'hfff000 | 24'd480);
          write_reg(REG_PROJ_DIST, 24'd141900);
        end
        4: begin
          write_reg(REG_SCREEN_HEIGHT, 24'h123000);
          write_reg(REG_PROJ_DIST, DIST_W'($urandom));
        end
        5: begin
          write_reg(REG_SCREEN_HEIGHT, 24'd4095);
          write_reg(REG_PROJ_DIST, 24'd141900);
        end
        default: begin
          write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'($urandom_range(1, 2048)));
          write_reg(REG_PROJ_DIST, CFG_DATA_W'($urandom_range(1000, 2000000)));
        end
      endcase
      settings_used++;
      no_idle = (phase == 2);
      repeat (ITEMS_PER_PHASE) send_random_ray();
    end
    no_idle = 1'b0;

    // Drain the pipeline and watch for stray span words.
    @(negedge clk);
    ray_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Projected %0d rays (%0d directed) under %0d register settings.",
             words_sent, directed_words, settings_used);
    $display("Checked %0d spans, %0d of them empty; %0d errors.",
             spans_checked, spans_empty, errors);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rwsp_pkg.sv
rtl/rwsp_if.sv
rtl/rwsp_cos_rom.sv
rtl/rwsp_div_step.sv
rtl/raycast_wall_slice_projection.sv
rtl/rwsp_checker.sv
sim/wall_span_checker.sv
sim/testbench.sv
